/* rtl/core/pvp_pkg.sv */
// shared types, constants and the matrix entry helper for the vertex projection block
// no dependencies

package pvp_pkg;

  localparam int SCREEN_SIZE = 1000;
  localparam int NUM_REGS    = 8;
  localparam int IDX_W       = 8;
  localparam int REG_W       = 64;
  localparam int COORD_W     = 32;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int FRAC_W      = 16;
  localparam int SUM_W       = PROD_W - FRAC_W + 2;
  localparam int VW_W        = SUM_W + 1;
  localparam int SS_W        = $clog2(SCREEN_SIZE + 1) + 1;
  localparam int NUM_W       = VW_W + SS_W;
  localparam int DEN_W       = SUM_W + 1;
  localparam int Q_W         = 17;
  localparam int CMP_W       = (DEN_W + Q_W > NUM_W ? DEN_W + Q_W : NUM_W) + 1;
  localparam int PIX_W       = 16;
  localparam int DIV_STAGES  = Q_W + 1;
  localparam int BACK_LAT    = DIV_STAGES + 2;
  localparam int FIFO_DEPTH  = 32;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_W       = 2 * PIX_W + 1;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'h1_0000);
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'h1_0000) << COORD_W;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

  localparam mat_t MAT_RESET = {ONE_HI, {REG_W{1'b0}}, ONE_LO, {REG_W{1'b0}},
                                {REG_W{1'b0}}, ONE_HI, {REG_W{1'b0}}, ONE_LO};

  typedef struct packed {
    logic                    vld;
    logic signed [SUM_W-1:0] hx;
    logic signed [SUM_W-1:0] hy;
    logic signed [SUM_W-1:0] hw;
  } xf_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_in_t;

  function automatic logic [COORD_W-1:0] mat_entry(mat_t m, int row, int col);
    logic [REG_W-1:0] r;
    r = m[row * 2 + col / 2];
    return (col % 2 == 1) ? r[REG_W-1:COORD_W] : r[COORD_W-1:0];
  endfunction

endpackage

/* rtl/core/perspective_vertex_projection.sv */
// top level of the perspective vertex projection block: matrix registers, credit count
// depends on pvp_pkg, pvp_front, pvp_back and pvp_fifo
//
// usage:
//   input queue: drive in_point_x/y/z (signed q16.16) and raise in_push; an item is
//   taken on a clock edge with in_push high and in_full low
//   result queue: while out_empty is low the oldest result is on out_screen_x,
//   out_screen_y and out_w_zero; raise out_pop to take it
//   config: cfg_valid with cfg_index and cfg_data writes one matrix register,
//   cfg_ready is always high; indexes past the last register are ignored
//   write the matrix only while no item is in flight
//   throughput: one item per cycle while in_full is low; the front multiplies in
//   one stage, the back divides one quotient bit per stage across 17 stages, both
//   fully pipelined
//   stall: the pipeline never stops; in_full rises once 32 items are accepted and not
//   yet popped, which is the result queue depth, so nothing is lost
//   reset: matrix returns to identity, queues and pipeline empty

module perspective_vertex_projection import pvp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [PIX_W-1:0] out_screen_x,
  output logic signed [PIX_W-1:0] out_screen_y,
  output logic                    out_w_zero,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  mat_t             mat_r;
  logic [CNT_W-1:0] credit_r;
  logic             acc, take;
  xf_t              xf;
  logic             res_vld;
  logic [OUT_W-1:0] res, rdata;

  assign cfg_ready = 1'b1;
  assign in_full   = (credit_r == CNT_W'(FIFO_DEPTH));
  assign acc       = in_push && !in_full;
  assign take      = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r    <= MAT_RESET;
      credit_r <= '0;
    end else begin
      if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
        mat_r[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
      end
      if (acc && !take) credit_r <= credit_r + CNT_W'(1);
      else if (!acc && take) credit_r <= credit_r - CNT_W'(1);
    end
  end

  pvp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z),
    .mat(mat_r), .xf(xf)
  );

  pvp_back u_back (
    .clk(clk), .rst_n(rst_n), .xf(xf), .res_vld(res_vld), .res(res)
  );

  pvp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(res_vld), .wdata(res),
    .pop(out_pop), .empty(out_empty), .rdata(rdata)
  );

  assign out_screen_x = rdata[OUT_W-1:PIX_W+1];
  assign out_screen_y = rdata[PIX_W:1];
  assign out_w_zero   = rdata[0];

endmodule

/* rtl/core/pvp_front.sv */
// front part: registers the vertex, forms the matrix products and row sums
// depends on pvp_pkg

module pvp_front import pvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [COORD_W-1:0] px,
  input  logic [COORD_W-1:0] py,
  input  logic [COORD_W-1:0] pz,
  input  mat_t               mat,
  output xf_t                xf
);

  // rows that reach an output: x, y and w
  localparam int ROWS [3] = '{0, 1, 3};

  logic                     vld_a_r, vld_b_r;
  logic [COORD_W-1:0]       pt_r [3];
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic [COORD_W-1:0]       off_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  xf_t                      xf_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(mat_entry(mat, ROWS[r], c)) * $signed(pt_r[c]);
      end
    end
  end

  // arithmetic shift is the floor of the q32.32 product to q32.16
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = SUM_W'($signed(prod_r[r][0][PROD_W-1:FRAC_W]))
                 + SUM_W'($signed(prod_r[r][1][PROD_W-1:FRAC_W]))
                 + SUM_W'($signed(prod_r[r][2][PROD_W-1:FRAC_W]))
                 + SUM_W'($signed(off_r[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      xf_r.vld <= 1'b0;
    end else begin
      vld_a_r  <= in_vld;
      vld_b_r  <= vld_a_r;
      xf_r.vld <= vld_b_r;
    end
    pt_r[0] <= px;
    pt_r[1] <= py;
    pt_r[2] <= pz;
    for (int r = 0; r < 3; r++) begin
      off_r[r] <= mat_entry(mat, ROWS[r], 3);
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= prod_nxt[r][c];
      end
    end
    xf_r.hx <= sum_nxt[0];
    xf_r.hy <= sum_nxt[1];
    xf_r.hw <= sum_nxt[2];
  end

  assign xf = xf_r;

endmodule

/* rtl/core/pvp_div.sv */
// one axis of the back part: restoring divide of magnitudes, one quotient bit per stage,
// then sign and saturation to a pixel; depends on pvp_pkg

module pvp_div import pvp_pkg::*; (
  input  logic                    clk,
  input  div_in_t                 din,
  output logic signed [PIX_W-1:0] pix
);

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [Q_W-1:0]   q_r   [DIV_STAGES];
  logic             neg_r [DIV_STAGES];
  logic             ovf_r [DIV_STAGES];
  logic [CMP_W-1:0] trial [DIV_STAGES];
  logic             ovf_nxt;
  logic signed [PIX_W-1:0] pix_r, pix_nxt;

  localparam logic [Q_W-1:0] POS_MAX = Q_W'((1 << (PIX_W - 1)) - 1);
  localparam logic [Q_W-1:0] NEG_MAX = Q_W'(1 << (PIX_W - 1));

  // quotient too wide for the stages at all
  assign ovf_nxt = CMP_W'(din.num) >= (CMP_W'(din.den) << Q_W);

  always_comb begin
    trial[0] = '0;
    for (int j = 1; j < DIV_STAGES; j++) begin
      trial[j] = CMP_W'(rem_r[j-1]) - (CMP_W'(den_r[j-1]) << (Q_W - j));
    end
  end

  always_comb begin
    if (neg_r[DIV_STAGES-1]) begin
      if (ovf_r[DIV_STAGES-1] || q_r[DIV_STAGES-1] > NEG_MAX) begin
        pix_nxt = PIX_W'(NEG_MAX);
      end else begin
        pix_nxt = PIX_W'(-q_r[DIV_STAGES-1]);
      end
    end else begin
      if (ovf_r[DIV_STAGES-1] || q_r[DIV_STAGES-1] > POS_MAX) begin
        pix_nxt = PIX_W'(POS_MAX);
      end else begin
        pix_nxt = PIX_W'(q_r[DIV_STAGES-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= din.num;
    den_r[0] <= din.den;
    neg_r[0] <= din.neg;
    ovf_r[0] <= ovf_nxt;
    q_r[0]   <= '0;
    for (int j = 1; j < DIV_STAGES; j++) begin
      den_r[j] <= den_r[j-1];
      neg_r[j] <= neg_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
      q_r[j]   <= q_r[j-1];
      if (!trial[j][CMP_W-1]) begin
        rem_r[j]       <= trial[j][NUM_W-1:0];
        q_r[j][Q_W-j]  <= 1'b1;
      end else begin
        rem_r[j] <= rem_r[j-1];
      end
    end
    pix_r <= pix_nxt;
  end

  assign pix = pix_r;

endmodule

/* rtl/core/pvp_back.sv */
// back part: forms numerators and denominators, runs both axis dividers,
// tracks valid and the zero w flag; depends on pvp_pkg and pvp_div

module pvp_back import pvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  xf_t                xf,
  output logic               res_vld,
  output logic [OUT_W-1:0]   res
);

  div_in_t                 dx_r, dy_r;
  logic                    vld_r [BACK_LAT];
  logic                    wz_r  [BACK_LAT];
  logic signed [PIX_W-1:0] sx, sy;

  function automatic div_in_t prep(logic signed [SUM_W-1:0] v, logic signed [SUM_W-1:0] w);
    logic signed [VW_W-1:0]  vw;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    div_in_t                 d;
    vw    = VW_W'(v) + VW_W'(w);
    num   = NUM_W'(vw) * $signed(NUM_W'(SCREEN_SIZE));
    den   = {w, 1'b0};
    d.num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    d.den = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    d.neg = num[NUM_W-1] ^ den[DEN_W-1];
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= xf.vld;
      for (int i = 1; i < BACK_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
    wz_r[0] <= (xf.hw == '0);
    for (int i = 1; i < BACK_LAT; i++) wz_r[i] <= wz_r[i-1];
    dx_r <= prep(xf.hx, xf.hw);
    dy_r <= prep(xf.hy, xf.hw);
  end

  pvp_div u_div_x (.clk(clk), .din(dx_r), .pix(sx));
  pvp_div u_div_y (.clk(clk), .din(dy_r), .pix(sy));

  // zero w gives zero pixels and the flag
  assign res_vld = vld_r[BACK_LAT-1];
  assign res = wz_r[BACK_LAT-1] ? {{(2 * PIX_W){1'b0}}, 1'b1} : {sx, sy, 1'b0};

endmodule

/* rtl/core/pvp_fifo.sv */
// result queue between the back part and the output port
// depends on pvp_pkg

module pvp_fifo import pvp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [OUT_W-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [OUT_W-1:0] rdata
);

  logic [OUT_W-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
